// File: rtl/scalar_kalman_filter_unit_defines.svh
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_UNIT_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_UNIT_DEFINES_SVH

// assertion on a rising clock edge, off while reset is high
`define SKF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on a rising clock edge that also covers the reset cycles
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, register codes, sequencer codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_ADDR_W    = 5;
   localparam int OPND_W        = DATA_W + 1;
   localparam int ACC_W         = DATA_W + 2;
   localparam int PROD_W        = 2 * OPND_W;

   typedef enum logic [2:0] {
      REG_STATE_COEFF      = 3'd0,
      REG_OBSERVE_COEFF    = 3'd1,
      REG_PROCESS_NOISE    = 3'd2,
      REG_MEASURE_NOISE    = 3'd3,
      REG_INITIAL_VARIANCE = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [DATA_W-1:0] state_coeff;
      logic [DATA_W-1:0] observe_coeff;
      logic [DATA_W-1:0] process_noise;
      logic [DATA_W-1:0] measure_noise;
   } cfg_type;

   typedef enum logic [1:0] {
      ADD_NONE,
      ADD_PLUS,
      ADD_RSUB
   } add_mode_type;

   typedef struct packed {
      logic         sat_unsigned;
      add_mode_type add_mode;
   } alu_op_type;

   typedef enum logic [3:0] {
      STEP_PRED,
      STEP_A2,
      STEP_PP,
      STEP_PH,
      STEP_H2,
      STEP_DEN,
      STEP_RES,
      STEP_XNEW,
      STEP_OMK,
      STEP_NP
   } step_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_WB,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FIN
   } state_type;

   function automatic logic [DATA_W-1:0] fx_one(input int frac);
      return DATA_W'(64'd1 << frac);
   endfunction

endpackage

`default_nettype wire

// File: rtl/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit
// One-dimensional Kalman filter in signed fixed point, one update per item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one measurement per item; rsp_* returns the filtered
//   estimate of that update. The csr_* port sets A, H, Q, R and an initial
//   variance that the filter does not read (byte addresses 0, 4, 8, 12, 16).
//   Write registers only while no update is in flight.
// Sequence:
//   Each item takes ten passes through the shared multiplier, plus the
//   restoring gain divider at one bit a cycle over 32 + FRAC_BITS bits.
//   A zero gain denominator skips the divider and sets the gain to zero.
//   req_tready is high only while the unit is idle.
// Reset:
//   Clears the estimate to zero, loads the default variance and restores
//   the CSR registers to their defaults; no result is pending.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted meanwhile, and its result waits until the earlier one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_unit import skf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [31:0] measurement
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // [31:0] estimate
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   assign csr_pready = 1'b1;

   skf_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   skf_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/skf_csr.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter register file
// APB-style write and read access to the five filter coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_csr import skf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output cfg_type               cfg
);

   localparam logic [DATA_W-1:0] ONE_RST = fx_one(FRAC_BITS);
   localparam logic [DATA_W-1:0] R_RST   =
      DATA_W'(((64'd1 << FRAC_BITS) * 64'd5 + 64'd50) / 64'd100);
   localparam logic [DATA_W-1:0] P0_RST  = DATA_W'(64'd10 << FRAC_BITS);

   logic [DATA_W-1:0] state_coeff_ff, state_coeff_in;
   logic [DATA_W-1:0] observe_coeff_ff, observe_coeff_in;
   logic [DATA_W-1:0] process_noise_ff, process_noise_in;
   logic [DATA_W-1:0] measure_noise_ff, measure_noise_in;
   logic [DATA_W-1:0] initial_variance_ff, initial_variance_in;
   reg_idx_type       idx;
   logic              wr_en;

   assign idx   = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      state_coeff_in      = state_coeff_ff;
      observe_coeff_in    = observe_coeff_ff;
      process_noise_in    = process_noise_ff;
      measure_noise_in    = measure_noise_ff;
      initial_variance_in = initial_variance_ff;
      if (wr_en) begin
         unique case (idx)
            REG_STATE_COEFF:      state_coeff_in      = csr_pwdata;
            REG_OBSERVE_COEFF:    observe_coeff_in    = csr_pwdata;
            REG_PROCESS_NOISE:    process_noise_in    = csr_pwdata;
            REG_MEASURE_NOISE:    measure_noise_in    = csr_pwdata;
            REG_INITIAL_VARIANCE: initial_variance_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_coeff_ff      <= ONE_RST;
         observe_coeff_ff    <= ONE_RST;
         process_noise_ff    <= '0;
         measure_noise_ff    <= R_RST;
         initial_variance_ff <= P0_RST;
      end else begin
         state_coeff_ff      <= state_coeff_in;
         observe_coeff_ff    <= observe_coeff_in;
         process_noise_ff    <= process_noise_in;
         measure_noise_ff    <= measure_noise_in;
         initial_variance_ff <= initial_variance_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_STATE_COEFF:      csr_prdata = state_coeff_ff;
         REG_OBSERVE_COEFF:    csr_prdata = observe_coeff_ff;
         REG_PROCESS_NOISE:    csr_prdata = process_noise_ff;
         REG_MEASURE_NOISE:    csr_prdata = measure_noise_ff;
         REG_INITIAL_VARIANCE: csr_prdata = initial_variance_ff;
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg = '{state_coeff:   state_coeff_ff,
                  observe_coeff: observe_coeff_ff,
                  process_noise: process_noise_ff,
                  measure_noise: measure_noise_ff};

endmodule

`default_nettype wire

// File: rtl/skf_alu.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter shared multiply unit
// Registered 33x33 product, then round half up, saturate, optional add or
// reverse subtract of an addend, and saturate again.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_alu import skf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic signed [OPND_W-1:0] opa,
   input  logic signed [OPND_W-1:0] opb,
   input  logic signed [ACC_W-1:0]  addend,
   input  alu_op_type               op,
   output logic signed [OPND_W-1:0] result
);

   localparam logic signed [PROD_W-1:0] HALF  =
      {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] U_MAX = {{(PROD_W-32){1'b0}}, 32'hFFFF_FFFF};
   localparam logic signed [PROD_W-1:0] S_MAX = {{(PROD_W-31){1'b0}}, 31'h7FFF_FFFF};
   localparam logic signed [PROD_W-1:0] S_MIN = {{(PROD_W-31){1'b1}}, 31'h0};

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  addend_ff;
   alu_op_type               op_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [OPND_W-1:0] r1;
   logic signed [PROD_W-1:0] r1_ext;
   logic signed [PROD_W-1:0] add_ext;
   logic signed [PROD_W-1:0] sum;

   function automatic logic signed [OPND_W-1:0] clamp(input logic signed [PROD_W-1:0] v,
                                                      input logic uns);
      logic signed [OPND_W-1:0] r;
      if (uns) begin
         if (v > U_MAX)  r = U_MAX[OPND_W-1:0];
         else if (v < 0) r = '0;
         else            r = v[OPND_W-1:0];
      end else begin
         if (v > S_MAX)      r = S_MAX[OPND_W-1:0];
         else if (v < S_MIN) r = S_MIN[OPND_W-1:0];
         else                r = v[OPND_W-1:0];
      end
      return r;
   endfunction

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      addend_ff <= addend;
      op_ff     <= op;
   end

   always_comb begin
      rnd     = (prod_ff + HALF) >>> FRAC_BITS;
      r1      = clamp(rnd, op_ff.sat_unsigned);
      r1_ext  = {{(PROD_W-OPND_W){r1[OPND_W-1]}}, r1};
      add_ext = {{(PROD_W-ACC_W){addend_ff[ACC_W-1]}}, addend_ff};
      unique case (op_ff.add_mode)
         ADD_PLUS: sum = add_ext + r1_ext;
         ADD_RSUB: sum = add_ext - r1_ext;
         default:  sum = r1_ext;
      endcase
      result = clamp(sum, op_ff.sat_unsigned);
   end

endmodule

`default_nettype wire

// File: rtl/skf_div.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter gain divider
// Restoring divider, one quotient bit a cycle: num * 2^FRAC_BITS / den,
// truncated toward zero and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div import skf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic [DATA_W-1:0]        den,
   output logic                     done,
   output logic signed [DATA_W-1:0] quot
);

   localparam int DVD_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W:0]   q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] mag;
   logic [DATA_W:0]   trial;
   logic              ge;

   always_comb begin
      mag     = num[DATA_W-1] ? (~num + 1'b1) : num;
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = {mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = num[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? DATA_W'(trial - {1'b0, den_ff}) : trial[DATA_W-1:0];
         q_in   = {q_ff[DATA_W-1:0], ge};
         ovf_in = ovf_ff | q_ff[DATA_W];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || q_ff > {1'b0, 32'h8000_0000}) quot = 32'sh8000_0000;
         else                                        quot = ~q_ff[DATA_W-1:0] + 1'b1;
      end else begin
         if (ovf_ff || q_ff > {1'b0, 32'h7FFF_FFFF}) quot = 32'sh7FFF_FFFF;
         else                                        quot = q_ff[DATA_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// File: rtl/skf_seq.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter sequencer
// Steps one update through the shared multiply unit and the gain divider,
// holds the filter state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_seq import skf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata
);

   localparam logic [DATA_W-1:0] ONE    = fx_one(FRAC_BITS);
   localparam logic [DATA_W-1:0] P0_RST = DATA_W'(64'd10 << FRAC_BITS);

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic [DATA_W-1:0] meas_ff, meas_in;
   logic [DATA_W-1:0] estimate_ff, estimate_in;
   logic [DATA_W-1:0] variance_ff, variance_in;
   logic [DATA_W-1:0] pred_ff, pred_in;
   logic [DATA_W-1:0] a2_ff, a2_in;
   logic [DATA_W-1:0] pp_ff, pp_in;
   logic [DATA_W-1:0] ph_ff, ph_in;
   logic [DATA_W-1:0] h2_ff, h2_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W-1:0] k_ff, k_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] omk_ff, omk_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_valid_ff, out_valid_in;

   logic                     accept;
   logic                     wb_en;
   logic                     div_start;
   logic                     div_done;
   logic                     load_out;
   logic                     den_zero;
   logic signed [OPND_W-1:0] opa;
   logic signed [OPND_W-1:0] opb;
   logic signed [ACC_W-1:0]  addend;
   alu_op_type               op;
   logic signed [OPND_W-1:0] alu_result;
   logic signed [DATA_W-1:0] div_quot;

   function automatic logic signed [OPND_W-1:0] ext_s(input logic [DATA_W-1:0] v);
      return {v[DATA_W-1], v};
   endfunction

   function automatic logic signed [OPND_W-1:0] ext_u(input logic [DATA_W-1:0] v);
      return {1'b0, v};
   endfunction

   assign den_zero = (den_ff == '0);

   skf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock  (clock),
      .opa    (opa),
      .opb    (opb),
      .addend (addend),
      .op     (op),
      .result (alu_result)
   );

   skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (ph_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_MUL;
         S_MUL:      state_in = S_WB;
         S_WB: begin
            if (step_ff == STEP_DEN)     state_in = S_DIV_GO;
            else if (step_ff == STEP_NP) state_in = S_FIN;
            else                         state_in = S_MUL;
         end
         S_DIV_GO:   state_in = den_zero ? S_MUL : S_DIV_WAIT;
         S_DIV_WAIT: if (div_done) state_in = S_MUL;
         S_FIN:      if (!out_valid_ff || rsp_tready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      accept     = req_tready & req_tvalid;
      wb_en      = (state_ff == S_WB);
      div_start  = (state_ff == S_DIV_GO) & ~den_zero;
      load_out   = (state_ff == S_FIN) & (~out_valid_ff | rsp_tready);
   end

   always_comb begin
      opa    = ext_s(cfg.state_coeff);
      opb    = ext_s(estimate_ff);
      addend = '0;
      op     = '{sat_unsigned: 1'b0, add_mode: ADD_NONE};
      unique case (step_ff)
         STEP_PRED: ;
         STEP_A2: begin
            opb = ext_s(cfg.state_coeff);
            op  = '{sat_unsigned: 1'b1, add_mode: ADD_NONE};
         end
         STEP_PP: begin
            opa    = ext_u(a2_ff);
            opb    = ext_u(variance_ff);
            addend = {2'b00, cfg.process_noise};
            op     = '{sat_unsigned: 1'b1, add_mode: ADD_PLUS};
         end
         STEP_PH: begin
            opa = ext_u(pp_ff);
            opb = ext_s(cfg.observe_coeff);
         end
         STEP_H2: begin
            opa = ext_s(cfg.observe_coeff);
            opb = ext_s(cfg.observe_coeff);
            op  = '{sat_unsigned: 1'b1, add_mode: ADD_NONE};
         end
         STEP_DEN: begin
            opa    = ext_u(pp_ff);
            opb    = ext_u(h2_ff);
            addend = {2'b00, cfg.measure_noise};
            op     = '{sat_unsigned: 1'b1, add_mode: ADD_PLUS};
         end
         STEP_RES: begin
            opa    = ext_s(cfg.observe_coeff);
            opb    = ext_s(pred_ff);
            addend = {{2{meas_ff[DATA_W-1]}}, meas_ff};
            op     = '{sat_unsigned: 1'b0, add_mode: ADD_RSUB};
         end
         STEP_XNEW: begin
            opa    = ext_s(k_ff);
            opb    = ext_s(res_ff);
            addend = {{2{pred_ff[DATA_W-1]}}, pred_ff};
            op     = '{sat_unsigned: 1'b0, add_mode: ADD_PLUS};
         end
         STEP_OMK: begin
            opa    = ext_s(k_ff);
            opb    = ext_s(cfg.observe_coeff);
            addend = {2'b00, ONE};
            op     = '{sat_unsigned: 1'b0, add_mode: ADD_RSUB};
         end
         STEP_NP: begin
            opa = ext_s(omk_ff);
            opb = ext_u(pp_ff);
            op  = '{sat_unsigned: 1'b1, add_mode: ADD_NONE};
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      meas_in      = meas_ff;
      estimate_in  = estimate_ff;
      variance_in  = variance_ff;
      pred_in      = pred_ff;
      a2_in        = a2_ff;
      pp_in        = pp_ff;
      ph_in        = ph_ff;
      h2_in        = h2_ff;
      den_in       = den_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      omk_in       = omk_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;

      if (accept) begin
         meas_in = req_tdata;
         step_in = STEP_PRED;
      end

      if (wb_en) begin
         unique case (step_ff)
            STEP_PRED: pred_in     = alu_result[DATA_W-1:0];
            STEP_A2:   a2_in       = alu_result[DATA_W-1:0];
            STEP_PP:   pp_in       = alu_result[DATA_W-1:0];
            STEP_PH:   ph_in       = alu_result[DATA_W-1:0];
            STEP_H2:   h2_in       = alu_result[DATA_W-1:0];
            STEP_DEN:  den_in      = alu_result[DATA_W-1:0];
            STEP_RES:  res_in      = alu_result[DATA_W-1:0];
            STEP_XNEW: estimate_in = alu_result[DATA_W-1:0];
            STEP_OMK:  omk_in      = alu_result[DATA_W-1:0];
            STEP_NP:   variance_in = alu_result[DATA_W-1:0];
            default: ;
         endcase
         if (step_ff != STEP_DEN && step_ff != STEP_NP) begin
            step_in = step_type'(step_ff + 4'd1);
         end
      end

      if (state_ff == S_DIV_GO && den_zero) begin
         k_in    = '0;
         step_in = STEP_RES;
      end

      if (state_ff == S_DIV_WAIT && div_done) begin
         k_in    = div_quot;
         step_in = STEP_RES;
      end

      if (load_out) begin
         out_data_in  = estimate_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_PRED;
         estimate_ff  <= '0;
         variance_ff  <= P0_RST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         estimate_ff  <= estimate_in;
         variance_ff  <= variance_in;
         out_valid_ff <= out_valid_in;
      end
      meas_ff     <= meas_in;
      pred_ff     <= pred_in;
      a2_ff       <= a2_in;
      pp_ff       <= pp_in;
      ph_ff       <= ph_in;
      h2_ff       <= h2_in;
      den_ff      <= den_in;
      k_ff        <= k_in;
      res_ff      <= res_in;
      omk_ff      <= omk_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// File: rtl/skf_checker.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter port checker
// Watches the stream ports of the unit over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scalar_kalman_filter_unit_defines.svh"

module skf_checker import skf_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata
);

   `SKF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled item changed or dropped")
   `SKF_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "ready while an update runs")
   `SKF_ASSERT(a_rsp_at_done, clock, reset, $rose(rsp_tvalid) |-> req_tready, "result shown before update finished")
   `SKF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_tready && !rsp_tvalid, "not idle after reset")

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
